/* design/nbrp_pkg.sv */
// Package: shared types, widths and codes of the row partitioner.
`timescale 1ns / 1ps
package nbrp_pkg;

    localparam int PTR_WIDTH_DEF = 32;
    localparam int NNZ_W         = 32;
    localparam int ROW_W         = 32;
    localparam int CNT_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int DIV_STEPS     = NNZ_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_NNZ   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UPDATE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NNZ_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NNZ_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* design/nbrp_row_if.sv */
// Interface: row pointer input channel.
`timescale 1ns / 1ps
interface nbrp_row_if #(
    parameter int PTR_WIDTH = 32
);
    logic                 valid;
    logic                 ready;
    logic [PTR_WIDTH-1:0] row_ptr;
    logic                 is_first;
    logic                 is_last;

    modport source (output valid, output row_ptr, output is_first, output is_last,
                    input ready);
    modport sink   (input valid, input row_ptr, input is_first, input is_last,
                    output ready);
endinterface

/* design/nbrp_set_if.sv */
// Interface: closed row set output channel.
`timescale 1ns / 1ps
interface nbrp_set_if;
    logic        valid;
    logic        ready;
    logic [10:0] set_index;
    logic [31:0] end_row;
    logic        overflow;

    modport source (output valid, output set_index, output end_row, output overflow,
                    input ready);
    modport sink   (input valid, input set_index, input end_row, input overflow,
                    output ready);
endinterface

/* design/nnz_balanced_row_partitioner.sv */
// Top level: nonzero-balanced CSR row partitioner with shared iterative divider.
//
//  channel  dir  handshake        payload
//  i_row    in   valid/ready      row_ptr, is_first, is_last
//  o_set    out  valid/ready      set_index, end_row, overflow
//  i_cfg_*  in   write enable     i_cfg_idx, i_cfg_data
//
// A pointer that closes no set is taken in IDLE. A pointer that closes a set
// passes DECIDE and UPDATE, and then DIV while the bit-serial divider works
// out a new target when one is needed. A first pointer goes through DIV.
// Reset is synchronous; the result register lets the next pointer in while
// a result waits, and a set close waits in DECIDE until that register frees.
`timescale 1ns / 1ps
module nnz_balanced_row_partitioner
    import nbrp_pkg::*;
#(
    parameter int PTR_WIDTH = PTR_WIDTH_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    nbrp_row_if.sink              i_row,
    nbrp_set_if.source            o_set
);

    localparam int WIDE_W = (PTR_WIDTH > NNZ_W) ? PTR_WIDTH : NNZ_W;
    localparam int SUM_W  = WIDE_W + 1;

    t_state r_state, n_state;

    logic [NNZ_W-1:0]     r_total_nnz;
    logic [CNT_W-1:0]     r_block_count;

    logic [PTR_WIDTH-1:0] r_prev_ptr;
    logic [PTR_WIDTH-1:0] r_cur_ptr;
    logic [ROW_W-1:0]     r_row_number;
    logic [PTR_WIDTH-1:0] r_start_ptr;
    logic [NNZ_W-1:0]     r_remaining_nnz;
    logic [CNT_W-1:0]     r_remaining_sets;
    logic [PTR_WIDTH-1:0] r_target;
    logic                 r_beyond;
    logic [CNT_W-1:0]     r_set_counter;
    logic [PTR_WIDTH-1:0] r_end_ptr;
    logic [PTR_WIDTH-1:0] r_base;

    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_index;
    logic [ROW_W-1:0]     r_out_row;
    logic                 r_out_ovf;

    logic [CNT_W-1:0]     bc_eff;
    logic                 row_acc;
    logic                 hit;
    logic                 slot_free;
    logic                 after;
    logic [PTR_WIDTH-1:0] diff_up;
    logic [PTR_WIDTH-1:0] diff_dn;
    logic [PTR_WIDTH-1:0] used;
    logic [WIDE_W-1:0]    used_ext;
    logic [WIDE_W-1:0]    rem_ext;
    logic [NNZ_W-1:0]     rem_new;
    logic [CNT_W-1:0]     sets_new;
    logic                 more_targets;
    logic [SUM_W-1:0]     target_sum;
    logic                 ready;
    logic                 load_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    nbrp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign bc_eff    = (r_block_count == '0) ? CNT_W'(1) : r_block_count;
    assign row_acc   = i_row.valid && ready;
    assign hit       = !r_beyond && (i_row.row_ptr >= r_target);
    assign slot_free = !r_out_valid || o_set.ready;

    // nearer end wins, tie closes after the row; prev above target closes before
    assign diff_up = r_cur_ptr - r_target;
    assign diff_dn = r_target - r_prev_ptr;
    assign after   = (r_prev_ptr <= r_target) && (diff_up <= diff_dn);

    assign used         = r_end_ptr - r_start_ptr;
    assign used_ext     = WIDE_W'(used);
    assign rem_ext      = WIDE_W'(r_remaining_nnz);
    assign rem_new      = (used_ext >= rem_ext) ? '0 : NNZ_W'(rem_ext - used_ext);
    assign sets_new     = (r_remaining_sets != '0) ? r_remaining_sets - 1'b1 : '0;
    assign more_targets = (r_set_counter < bc_eff) && (sets_new != '0);

    assign target_sum = SUM_W'(r_base) + SUM_W'(div_rsp.quotient);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (row_acc) begin
                    if (i_row.is_first) n_state = ST_DIV;
                    else if (hit)       n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (slot_free) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = more_targets ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_rsp.done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ready            = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_total_nnz;
        div_req.divisor  = bc_eff;
        case (r_state)
            ST_IDLE: begin
                ready         = 1'b1;
                div_req.start = row_acc && i_row.is_first;
            end
            ST_DECIDE: begin
                load_out = slot_free;
            end
            ST_UPDATE: begin
                div_req.start    = more_targets;
                div_req.dividend = rem_new;
                div_req.divisor  = sets_new;
            end
            ST_DIV: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_total_nnz   <= '0;
            r_block_count <= CNT_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL_NNZ:   r_total_nnz   <= i_cfg_data[NNZ_W-1:0];
                    REG_BLOCK_COUNT: r_block_count <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (load_out)         r_out_valid <= 1'b1;
            else if (o_set.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ptr       <= '0;
            r_row_number     <= '0;
            r_start_ptr      <= '0;
            r_remaining_nnz  <= '0;
            r_remaining_sets <= '0;
            r_target         <= '0;
            r_beyond         <= 1'b0;
            r_set_counter    <= CNT_W'(1);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (row_acc) begin
                        r_cur_ptr <= i_row.row_ptr;
                        if (i_row.is_first) begin
                            r_prev_ptr       <= i_row.row_ptr;
                            r_start_ptr      <= i_row.row_ptr;
                            r_row_number     <= '0;
                            r_remaining_nnz  <= r_total_nnz;
                            r_remaining_sets <= bc_eff;
                            r_set_counter    <= CNT_W'(1);
                            r_base           <= '0;
                        end else if (!hit) begin
                            r_prev_ptr   <= i_row.row_ptr;
                            r_row_number <= r_row_number + 1'b1;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (slot_free) begin
                        r_end_ptr   <= after ? r_cur_ptr : r_prev_ptr;
                        r_out_index <= r_set_counter;
                        r_out_row   <= after ? r_row_number + 1'b1 : r_row_number;
                        r_out_ovf   <= r_set_counter > bc_eff;
                    end
                end
                ST_UPDATE: begin
                    r_remaining_nnz  <= rem_new;
                    r_remaining_sets <= sets_new;
                    r_start_ptr      <= r_end_ptr;
                    r_base           <= r_end_ptr;
                    r_prev_ptr       <= r_cur_ptr;
                    r_row_number     <= r_row_number + 1'b1;
                    if (r_set_counter != CNT_MAX) r_set_counter <= r_set_counter + 1'b1;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_target <= target_sum[PTR_WIDTH-1:0];
                        r_beyond <= (target_sum >> PTR_WIDTH) != '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_row.ready     = ready;
    assign o_set.valid     = r_out_valid;
    assign o_set.set_index = r_out_index;
    assign o_set.end_row   = r_out_row;
    assign o_set.overflow  = r_out_ovf;

endmodule

/* design/nbrp_divider.sv */
// Module: restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nbrp_divider
    import nbrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NNZ_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dsr;

    logic [CNT_W:0]       rem_sh;
    logic                 fits;

    // partial remainder stays below the divisor, so CNT_W bits hold it
    assign rem_sh = {r_rem, r_quo[NNZ_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? CNT_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[NNZ_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
